### src/pid_controller_clamped_unit_assert.svh
// Assertion macros for the PID controller unit.
// Included by the top level; relies on a clock named clk and a reset named rst.
`ifndef PID_CONTROLLER_CLAMPED_UNIT_ASSERT_SVH
`define PID_CONTROLLER_CLAMPED_UNIT_ASSERT_SVH

// Condition in the same cycle.
`define PCC_ASSERT_NOW(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("pcc assertion failed");

// Consequence checked in the next cycle.
`define PCC_ASSERT_NEXT(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("pcc assertion failed");

`endif

### src/pcc_pkg.sv
// Package for the PID controller unit: register indexes, microcode types and
// the microcode table. No dependencies.
package pcc_pkg;

  localparam int StepW = 3;
  localparam logic [StepW-1:0] STEP_IDLE = 3'd0;
  localparam logic [StepW-1:0] STEP_OUT  = 3'd7;

  // Configuration register indexes.
  localparam logic [2:0] REG_KP      = 3'd0;
  localparam logic [2:0] REG_KI      = 3'd1;
  localparam logic [2:0] REG_KD      = 3'd2;
  localparam logic [2:0] REG_DT      = 3'd3;
  localparam logic [2:0] REG_INV_DT  = 3'd4;
  localparam logic [2:0] REG_MIN_OUT = 3'd5;
  localparam logic [2:0] REG_MAX_OUT = 3'd6;

  typedef enum logic [1:0] {X_ERR, X_DIFF, X_KI, X_KD} x_sel_t;
  typedef enum logic [2:0] {Y_DT, Y_KP, Y_INV_DT, Y_INTEG, Y_R} y_sel_t;
  typedef enum logic [2:0] {
    OP_CAPTURE, OP_DIFF, OP_INTEG, OP_LOAD_ACC, OP_LOAD_R, OP_ADD_ACC,
    OP_ADD_COMMIT, OP_OUT
  } dp_op_t;
  typedef enum logic [1:0] {SEQ_NEXT, SEQ_WAIT_IN, SEQ_WAIT_OUT} seq_t;

  typedef struct packed {
    x_sel_t x_sel;
    y_sel_t y_sel;
    dp_op_t op;
    seq_t   seq;
  } ctrl_word_t;

  // One control word per step. The multiplier result of a step is consumed
  // by the datapath operation of the following step.
  function automatic ctrl_word_t ucode(input logic [StepW-1:0] step);
    ctrl_word_t cw;
    unique case (step)
      3'd0:    cw = '{X_ERR,  Y_DT,     OP_CAPTURE,    SEQ_WAIT_IN};
      3'd1:    cw = '{X_ERR,  Y_DT,     OP_DIFF,       SEQ_NEXT};
      3'd2:    cw = '{X_ERR,  Y_KP,     OP_INTEG,      SEQ_NEXT};
      3'd3:    cw = '{X_DIFF, Y_INV_DT, OP_LOAD_ACC,   SEQ_NEXT};
      3'd4:    cw = '{X_KI,   Y_INTEG,  OP_LOAD_R,     SEQ_NEXT};
      3'd5:    cw = '{X_KD,   Y_R,      OP_ADD_ACC,    SEQ_NEXT};
      3'd6:    cw = '{X_ERR,  Y_DT,     OP_ADD_COMMIT, SEQ_NEXT};
      default: cw = '{X_ERR,  Y_DT,     OP_OUT,        SEQ_WAIT_OUT};
    endcase
    return cw;
  endfunction

endpackage

### src/pcc_channels.sv
// Handshake channel interfaces of the PID controller unit: sample input,
// result output and configuration writes. No dependencies.
interface pcc_sample_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] setpoint;
  logic signed [23:0] measured;
  modport source (output valid, setpoint, measured, input ready);
  modport sink (input valid, setpoint, measured, output ready);
endinterface

interface pcc_result_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] drive;
  logic               clamped;
  modport source (output valid, drive, clamped, input ready);
  modport sink (input valid, drive, clamped, output ready);
endinterface

interface pcc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/pid_controller_clamped_unit.sv
// PID controller with clamped output, microcoded over one shared multiplier.
// Uses pcc_pkg, the channel interfaces and the assertion macro header.
//
// Channels: sample (setpoint, measured) in, result (drive, clamped) out, and
// cfg, a write port for the gains, time step, reciprocal and output limits.
// cfg is always ready; a write to an index past the register list is ignored.
// Writes are expected only while no sample is in progress.
//
// A sample word is taken while the sequencer sits in its idle step. Seven
// more steps follow: the error difference, the integral update, and the
// proportional, integral and derivative products, each through one 26 x 36
// signed multiplier whose product is registered. The result enters the output
// register at the last step. A new sample is taken only once the sequencer
// has returned to its idle step, so samples do not overlap; the sequencer
// length and the single multiplier set the sample rate.
//
// If the receiver stalls, the finished result waits in the output register and
// the sequencer holds at its last step until the slot frees; the next sample
// is not taken meanwhile. Reset clears the integral and the stored error,
// loads the register defaults and empties the output register.
`include "pid_controller_clamped_unit_assert.svh"

module pid_controller_clamped_unit
  import pcc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  pcc_sample_if.sink          sample,
  pcc_result_if.source        result,
  pcc_cfg_if.sink             cfg
);

  // Configuration registers.
  logic signed [15:0] kp, ki, kd;
  logic        [15:0] dt, inv_dt;
  logic signed [23:0] min_out, max_out;

  // State carried from sample to sample.
  logic signed [31:0] integ;
  logic signed [24:0] last_error;

  // Working registers.
  logic signed [24:0] err;
  logic signed [25:0] diff;
  logic signed [34:0] r;
  logic signed [44:0] acc;
  logic signed [61:0] prod;

  logic [StepW-1:0] step, step_next;
  ctrl_word_t       cw;

  logic               out_valid;
  logic signed [23:0] drive_q;
  logic               clamped_q;
  logic               out_load;

  logic signed [25:0] mx;
  logic signed [35:0] my;
  logic signed [32:0] integ_sum;
  logic signed [44:0] max_ext, min_ext, res_hi, res;
  logic               hit_hi, hit_lo;

  assign cw = ucode(step);

  // Configuration port.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp      <= '0;
      ki      <= '0;
      kd      <= '0;
      dt      <= 16'd6554;
      inv_dt  <= 16'd2560;
      min_out <= '0;
      max_out <= 24'sd25600;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_KP:      kp      <= cfg.data[15:0];
        REG_KI:      ki      <= cfg.data[15:0];
        REG_KD:      kd      <= cfg.data[15:0];
        REG_DT:      dt      <= cfg.data[15:0];
        REG_INV_DT:  inv_dt  <= cfg.data[15:0];
        REG_MIN_OUT: min_out <= cfg.data;
        REG_MAX_OUT: max_out <= cfg.data;
        default: ;
      endcase
    end
  end

  // Sequencer.
  assign sample.ready = (cw.seq == SEQ_WAIT_IN);
  assign out_load     = (cw.seq == SEQ_WAIT_OUT) && (!out_valid || result.ready);

  always_comb begin
    step_next = step;
    unique case (cw.seq)
      SEQ_NEXT:     step_next = step + 3'd1;
      SEQ_WAIT_IN:  if (sample.valid) step_next = step + 3'd1;
      SEQ_WAIT_OUT: if (out_load) step_next = STEP_IDLE;
      default:      step_next = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // Shared multiplier operands.
  always_comb begin
    unique case (cw.x_sel)
      X_ERR:   mx = {err[24], err};
      X_DIFF:  mx = diff;
      X_KI:    mx = {{10{ki[15]}}, ki};
      X_KD:    mx = {{10{kd[15]}}, kd};
      default: mx = '0;
    endcase
    unique case (cw.y_sel)
      Y_DT:     my = {20'd0, dt};
      Y_KP:     my = {{20{kp[15]}}, kp};
      Y_INV_DT: my = {20'd0, inv_dt};
      Y_INTEG:  my = {{4{integ[31]}}, integ};
      Y_R:      my = {r[34], r};
      default:  my = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mx * my;
  end

  // Integral update: the added term is the product shifted right by 16.
  assign integ_sum = {integ[31], integ} + prod[48:16];

  // Output clamp: upper limit first, then the lower limit.
  assign max_ext = {{21{max_out[23]}}, max_out};
  assign min_ext = {{21{min_out[23]}}, min_out};
  assign hit_hi  = acc > max_ext;
  assign res_hi  = hit_hi ? max_ext : acc;
  assign hit_lo  = res_hi < min_ext;
  assign res     = hit_lo ? min_ext : res_hi;

  // Working registers.
  always_ff @(posedge clk) begin
    unique case (cw.op)
      OP_CAPTURE: begin
        if (sample.valid) begin
          err <= {sample.setpoint[23], sample.setpoint}
               - {sample.measured[23], sample.measured};
        end
      end
      OP_DIFF:       diff <= {err[24], err} - {last_error[24], last_error};
      OP_LOAD_ACC:   acc  <= prod[52:8];
      OP_LOAD_R:     r    <= prod[42:8];
      OP_ADD_ACC:    acc  <= acc + prod[52:8];
      OP_ADD_COMMIT: acc  <= acc + prod[52:8];
      default: ;
    endcase
  end

  // Carried state.
  always_ff @(posedge clk) begin
    if (rst) begin
      integ      <= '0;
      last_error <= '0;
    end else begin
      if (cw.op == OP_INTEG) begin
        if (integ_sum[32] != integ_sum[31]) begin
          integ <= integ_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
          integ <= integ_sum[31:0];
        end
      end
      if (cw.op == OP_ADD_COMMIT) begin
        last_error <= err;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      drive_q   <= res[23:0];
      clamped_q <= hit_hi || hit_lo;
    end
  end

  assign result.valid   = out_valid;
  assign result.drive   = drive_q;
  assign result.clamped = clamped_q;

  `PCC_ASSERT_NEXT(a_busy_after_accept, sample.valid && sample.ready, !sample.ready)
  `PCC_ASSERT_NOW(a_drive_in_limits,
    out_valid && (max_out >= min_out),
    (drive_q <= max_out) && (drive_q >= min_out))
  `PCC_ASSERT_NEXT(a_hold_on_stall,
    (step == STEP_OUT) && out_valid && !result.ready,
    step == STEP_OUT)

endmodule
